// ===== src/command_apdu_parser_core_assert.svh =====
// ---------------------------------------------------------------------------
// command apdu parser assertion macros
// immediate-consequence and next-cycle checks, clocked on clk, off in reset
// ---------------------------------------------------------------------------
`ifndef COMMAND_APDU_PARSER_CORE_ASSERT_SVH
`define COMMAND_APDU_PARSER_CORE_ASSERT_SVH

// consequence holds in the same cycle as the antecedent
`define CAP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequence holds in the cycle after the antecedent
`define CAP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/cap_pkg.sv =====
// ---------------------------------------------------------------------------
// cap_pkg
// transaction types and apdu case codes for the command apdu parser
// ---------------------------------------------------------------------------
package cap_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       final_byte;
  } cap_in_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  body_byte;
    logic [15:0] body_index;
    logic [7:0]  class_byte;
    logic [7:0]  instruction;
    logic [7:0]  param_one;
    logic [7:0]  param_two;
    logic [15:0] command_length;
    logic [16:0] expected_length;
    logic [2:0]  apdu_case;
    logic        malformed;
    logic        end_of_run;
  } cap_out_t;

  typedef struct packed {
    logic push0;
    logic push1;
  } cap_push_t;

  localparam logic        KIND_DATA    = 1'b0;
  localparam logic        KIND_SUMMARY = 1'b1;

  localparam logic [2:0]  CASE_1    = 3'd0;
  localparam logic [2:0]  CASE_2S   = 3'd1;
  localparam logic [2:0]  CASE_3S   = 3'd2;
  localparam logic [2:0]  CASE_4S   = 3'd3;
  localparam logic [2:0]  CASE_2E   = 3'd4;
  localparam logic [2:0]  CASE_3E   = 3'd5;
  localparam logic [2:0]  CASE_4E   = 3'd6;
  localparam logic [2:0]  CASE_NONE = 3'd7;

  localparam logic [16:0] COUNT_MAX     = 17'h1FFFF;
  localparam logic [16:0] LE_SHORT_DFLT = 17'h00100;
  localparam logic [16:0] LE_EXT_DFLT   = 17'h10000;

endpackage

// ===== src/cap_decode.sv =====
// ---------------------------------------------------------------------------
// cap_decode
// per-byte parser state, header capture, length decode and result build
// ---------------------------------------------------------------------------
`include "command_apdu_parser_core_assert.svh"

module cap_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  cap_pkg::cap_in_t  in_data,
  output cap_pkg::cap_push_t push,
  output cap_pkg::cap_out_t res0,
  output cap_pkg::cap_out_t res1
);
  import cap_pkg::*;

  logic [16:0] byte_count_r, byte_count_nxt;
  logic [7:0]  class_r, class_nxt;
  logic [7:0]  ins_r, ins_nxt;
  logic [7:0]  p1_r, p1_nxt;
  logic [7:0]  p2_r, p2_nxt;
  logic [7:0]  sl_r, sl_nxt;
  logic [15:0] el_r, el_nxt;
  logic [15:0] trailer_r, trailer_nxt;

  logic [7:0]  b;
  logic        fin;
  logic [17:0] p18;
  logic [17:0] sl18;
  logic [17:0] el18;
  logic        data_hit;
  logic [15:0] data_idx;
  logic [17:0] len18;
  logic [15:0] lc;
  logic [16:0] le;
  logic [2:0]  cs;
  logic [17:0] sl_s18;
  logic [17:0] el_s18;
  cap_out_t    data_res;
  cap_out_t    summ_res;

  assign b    = in_data.in_byte;
  assign fin  = in_data.final_byte;
  assign p18  = {1'b0, byte_count_r};
  assign sl18 = {10'd0, sl_r};
  assign el18 = {2'd0, el_r};

  always_comb begin
    class_nxt   = class_r;
    ins_nxt     = ins_r;
    p1_nxt      = p1_r;
    p2_nxt      = p2_r;
    sl_nxt      = sl_r;
    el_nxt      = el_r;
    trailer_nxt = trailer_r;
    data_hit    = 1'b0;
    data_idx    = '0;
    if (p18 == 18'd0) begin
      class_nxt = b;
    end else if (p18 == 18'd1) begin
      ins_nxt = b;
    end else if (p18 == 18'd2) begin
      p1_nxt = b;
    end else if (p18 == 18'd3) begin
      p2_nxt = b;
    end else if (p18 == 18'd4) begin
      sl_nxt = b;
    end else if (sl_r != 8'd0) begin
      // short form
      if (p18 <= sl18 + 18'd4) begin
        data_hit = 1'b1;
        data_idx = 16'(p18 - 18'd5);
      end else if (p18 == sl18 + 18'd5) begin
        trailer_nxt = {8'd0, b};
      end
    end else begin
      // extended form
      if (p18 == 18'd5) begin
        el_nxt = {b, 8'd0};
      end else if (p18 == 18'd6) begin
        el_nxt = el_r | {8'd0, b};
      end else if (el_r != 16'd0) begin
        if (p18 <= el18 + 18'd6) begin
          data_hit = 1'b1;
          data_idx = 16'(p18 - 18'd7);
        end else if (p18 == el18 + 18'd7 || p18 == el18 + 18'd8) begin
          trailer_nxt = {trailer_r[7:0], b};
        end
      end
    end
  end

  always_comb begin
    byte_count_nxt = (byte_count_r != COUNT_MAX) ? byte_count_r + 17'd1 : byte_count_r;
    len18  = {1'b0, byte_count_nxt};
    sl_s18 = {10'd0, sl_nxt};
    el_s18 = {2'd0, el_nxt};
    lc     = '0;
    le     = '0;
    cs     = CASE_NONE;
    if (len18 == 18'd4) begin
      cs = CASE_1;
    end else if (len18 == 18'd5) begin
      cs = CASE_2S;
      le = (sl_nxt != 8'd0) ? {9'd0, sl_nxt} : LE_SHORT_DFLT;
    end else if (len18 > 18'd5 && sl_nxt != 8'd0) begin
      if (len18 == sl_s18 + 18'd5) begin
        cs = CASE_3S;
        lc = {8'd0, sl_nxt};
        le = LE_SHORT_DFLT;
      end else if (len18 == sl_s18 + 18'd6) begin
        cs = CASE_4S;
        lc = {8'd0, sl_nxt};
        le = (trailer_nxt[7:0] != 8'd0) ? {9'd0, trailer_nxt[7:0]} : LE_SHORT_DFLT;
      end
    end else if (len18 > 18'd5) begin
      if (len18 == 18'd7) begin
        cs = CASE_2E;
        le = (el_nxt != 16'd0) ? {1'b0, el_nxt} : LE_EXT_DFLT;
      end else if (len18 > 18'd7 && el_nxt != 16'd0) begin
        if (len18 == el_s18 + 18'd7) begin
          cs = CASE_3E;
          lc = el_nxt;
          le = LE_EXT_DFLT;
        end else if (len18 == el_s18 + 18'd9) begin
          cs = CASE_4E;
          lc = el_nxt;
          le = (trailer_nxt != 16'd0) ? {1'b0, trailer_nxt} : LE_EXT_DFLT;
        end
      end
    end
  end

  always_comb begin
    data_res            = '0;
    data_res.kind       = KIND_DATA;
    data_res.body_byte  = b;
    data_res.body_index = data_idx;
    data_res.end_of_run = !fin;

    summ_res                 = '0;
    summ_res.kind            = KIND_SUMMARY;
    summ_res.class_byte      = class_nxt;
    summ_res.instruction     = ins_nxt;
    summ_res.param_one       = p1_nxt;
    summ_res.param_two       = p2_nxt;
    summ_res.command_length  = lc;
    summ_res.expected_length = le;
    summ_res.apdu_case       = cs;
    summ_res.malformed       = (cs == CASE_NONE);
    summ_res.end_of_run      = 1'b1;
  end

  assign res0       = data_hit ? data_res : summ_res;
  assign res1       = summ_res;
  assign push.push0 = accept && (data_hit || fin);
  assign push.push1 = accept && data_hit && fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      class_r      <= '0;
      ins_r        <= '0;
      p1_r         <= '0;
      p2_r         <= '0;
      sl_r         <= '0;
      el_r         <= '0;
      trailer_r    <= '0;
    end else if (accept) begin
      if (fin) begin
        byte_count_r <= '0;
        class_r      <= '0;
        ins_r        <= '0;
        p1_r         <= '0;
        p2_r         <= '0;
        sl_r         <= '0;
        el_r         <= '0;
        trailer_r    <= '0;
      end else begin
        byte_count_r <= byte_count_nxt;
        class_r      <= class_nxt;
        ins_r        <= ins_nxt;
        p1_r         <= p1_nxt;
        p2_r         <= p2_nxt;
        sl_r         <= sl_nxt;
        el_r         <= el_nxt;
        trailer_r    <= trailer_nxt;
      end
    end
  end

  `CAP_ASSERT_NEXT(a_clear_after_final, accept && in_data.final_byte, byte_count_r == 17'd0)
  `CAP_ASSERT_IMPL(a_body_after_len, push.push0 && !res0.kind, byte_count_r >= 17'd5)
  `CAP_ASSERT_IMPL(a_malformed_case, push.push0 && res0.kind, res0.malformed == (res0.apdu_case == CASE_NONE))

endmodule

// ===== src/cap_fifo.sv =====
// ---------------------------------------------------------------------------
// cap_fifo
// small result queue taking up to two results per cycle, one out per cycle while out_stall is low
// ---------------------------------------------------------------------------
`include "command_apdu_parser_core_assert.svh"

module cap_fifo #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cap_pkg::cap_push_t push,
  input  cap_pkg::cap_out_t  res0,
  input  cap_pkg::cap_out_t  res1,
  output logic               full2,
  output logic               out_valid,
  input  logic               out_stall,
  output cap_pkg::cap_out_t  out_data
);
  import cap_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cap_out_t        mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [PW-1:0]   wr_ptr_p1;
  logic            pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] ptr);
    logic [PW-1:0] r;
    if (ptr == PW'(DEPTH - 1)) r = '0;
    else r = ptr + 1'b1;
    return r;
  endfunction

  assign wr_ptr_p1 = ptr_inc(wr_ptr_r);
  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign full2     = (count_r > CW'(DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (push.push1) wr_ptr_nxt = ptr_inc(wr_ptr_p1);
    else if (push.push0) wr_ptr_nxt = wr_ptr_p1;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CW'(push.push0) + CW'(push.push1) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.push0) mem_r[wr_ptr_r] <= res0;
    if (push.push1) mem_r[wr_ptr_p1] <= res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `CAP_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CW'(DEPTH))
  `CAP_ASSERT_IMPL(a_room_for_pair, push.push0, count_r <= CW'(DEPTH - 2))
  `CAP_ASSERT_IMPL(a_pair_order, push.push1, push.push0)

endmodule

// ===== src/command_apdu_parser_core.sv =====
// ---------------------------------------------------------------------------
// command_apdu_parser_core: streaming iso 7816-4 command apdu parser
// path: an accepted byte's results are built combinationally and written into the registered result queue
// throughput: one byte per cycle while in_stall is low; a final byte that ends the data field queues two results
// reset: synchronous active-low rst_n clears the parser state and the result queue
// ---------------------------------------------------------------------------
module command_apdu_parser_core #(
  parameter int RESULT_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cap_pkg::cap_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output cap_pkg::cap_out_t out_data
);
  import cap_pkg::*;

  cap_push_t push;
  cap_out_t  res0;
  cap_out_t  res1;
  logic      full2;
  logic      accept;

  assign in_stall = full2;
  assign accept   = in_valid && !in_stall;

  cap_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .push    (push),
    .res0    (res0),
    .res1    (res1)
  );

  cap_fifo #(
    .DEPTH (RESULT_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .res0      (res0),
    .res1      (res1),
    .full2     (full2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
